/* hw/rtl/rds_group_text_decoder_defines.svh */
// assertion macros shared by the rds group text decoder rtl
// no dependencies; included by the files that carry assertions
`ifndef RDS_GROUP_TEXT_DECODER_DEFINES_SVH
`define RDS_GROUP_TEXT_DECODER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RGTD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RGTD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rgtd_pkg.sv */
// types, constants and the character cleaning function of the rds group text decoder
// no dependencies
`default_nettype none

package rgtd_pkg;

    typedef enum logic [1:0] {
        MODE_DECODE  = 2'd0,
        MODE_READ_PS = 2'd1,
        MODE_READ_RT = 2'd2,
        MODE_CLEAR   = 2'd3
    } t_mode;

    localparam int SVC_DEPTH = 8;
    localparam int TXT_DEPTH = 64;
    localparam int SVC_AW    = 3;
    localparam int TXT_AW    = 6;

    localparam logic [15:0] C_STATUS_AVAIL = 16'h8000;
    localparam logic [15:0] C_ERR_MASK     = 16'h0a00;
    localparam logic [7:0]  C_CR           = 8'h0D;
    localparam logic [7:0]  C_SPACE        = 8'h20;
    localparam logic [7:0]  C_CHAR_MAX     = 8'd126;
    localparam logic [3:0]  GRP_PS         = 4'd0;
    localparam logic [3:0]  GRP_RT         = 4'd2;

    // control and high characters become spaces, zero passes
    function automatic logic [7:0] clean_char(input logic [7:0] c);
        logic [7:0] res;
        if ((c != 8'd0 && c < C_SPACE) || c > C_CHAR_MAX) begin
            res = C_SPACE;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rgtd_ram.sv */
// single-write, single-read synchronous character ram with per-entry valid bits
// an entry never written since reset or clear reads as zero; no dependencies
`default_nettype none

module rgtd_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_clr,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
            r_rvld  <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

/* hw/rtl/rds_group_text_decoder.sv */
// rds group decoder: programme service and radio text stores, one command at a time
// a read or clear goes through S_FINISH to the o_valid strobe; an accepted group 0 or 2
// decode passes S_WRITE first, and S_FILL too when a carriage return starts a fill
// the text ram has one write port, so bytes and fill positions go in one per cycle
// synchronous active-low reset empties both rams and clears pty, pi and the text flags
// results cannot be stalled; busy rises after the start beat and falls as o_valid rises
`default_nettype none
`include "rds_group_text_decoder_defines.svh"

module rds_group_text_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic        i_read_ok,
    input  wire logic [15:0] i_rds_status,
    input  wire logic [15:0] i_error_flags,
    input  wire logic [15:0] i_block_a,
    input  wire logic [15:0] i_block_b,
    input  wire logic [15:0] i_block_c,
    input  wire logic [15:0] i_block_d,
    input  wire logic [5:0]  i_char_index,
    output logic             o_valid,
    output logic             o_accepted,
    output logic             o_service_complete,
    output logic             o_new_text,
    output logic [4:0]       o_program_type,
    output logic [15:0]      o_program_id,
    output logic [7:0]       o_char_value
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRITE,
        S_FILL,
        S_FINISH
    } t_state;

    t_state                          r_state;
    rgtd_pkg::t_mode                 r_mode;
    logic [7:0]                      r_bytes [4];
    logic [1:0]                      r_k;
    logic [1:0]                      r_last;
    logic [rgtd_pkg::TXT_AW-1:0]     r_base;
    logic [rgtd_pkg::TXT_AW-1:0]     r_fill;
    logic                            r_to_svc;
    logic                            r_is_2a;
    logic                            r_cr;
    logic                            r_svc_oor;
    logic                            r_acc;
    logic                            r_cplt;
    logic                            r_last_ab;
    logic                            r_new_text;
    logic [4:0]                      r_type;
    logic [15:0]                     r_id;
    logic                            r_valid;
    logic                            r_out_acc;
    logic                            r_out_cplt;
    logic                            r_out_new;
    logic [4:0]                      r_out_type;
    logic [15:0]                     r_out_id;
    logic [7:0]                      r_out_char;

    logic                            accept;
    logic                            grp_ok;
    logic [3:0]                      gtype;
    logic                            clr;
    logic [7:0]                      wr_byte;
    logic [rgtd_pkg::TXT_AW-1:0]     wr_pos;
    logic                            svc_we;
    logic                            txt_we;
    logic [rgtd_pkg::TXT_AW-1:0]     txt_waddr;
    logic [7:0]                      txt_wdata;
    logic [7:0]                      svc_wdata;
    logic                            svc_re;
    logic                            txt_re;
    logic [7:0]                      svc_rdata;
    logic [7:0]                      txt_rdata;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign gtype  = i_block_b[15:12];
    assign grp_ok = i_read_ok && (i_block_b != 16'd0)
                 && ((i_rds_status & rgtd_pkg::C_STATUS_AVAIL) != 16'd0)
                 && ((i_error_flags & rgtd_pkg::C_ERR_MASK) == 16'd0);
    assign clr    = accept && (rgtd_pkg::t_mode'(i_mode) == rgtd_pkg::MODE_CLEAR);
    assign svc_re = accept && (rgtd_pkg::t_mode'(i_mode) == rgtd_pkg::MODE_READ_PS);
    assign txt_re = accept && (rgtd_pkg::t_mode'(i_mode) == rgtd_pkg::MODE_READ_RT);

    assign wr_byte   = r_bytes[r_k];
    assign wr_pos    = r_base + rgtd_pkg::TXT_AW'(r_k);
    assign svc_wdata = rgtd_pkg::clean_char(wr_byte);

    always_comb begin
        svc_we    = 1'b0;
        txt_we    = 1'b0;
        txt_waddr = wr_pos;
        txt_wdata = rgtd_pkg::clean_char(wr_byte);
        if (r_state == S_WRITE) begin
            if (r_is_2a) begin
                txt_we = (wr_byte != rgtd_pkg::C_CR);
            end else if (wr_byte != 8'd0) begin
                svc_we = r_to_svc;
                txt_we = !r_to_svc;
            end
        end else if (r_state == S_FILL) begin
            txt_we    = 1'b1;
            txt_waddr = r_fill;
            txt_wdata = rgtd_pkg::C_SPACE;
        end
    end

    rgtd_ram #(
        .DEPTH (rgtd_pkg::SVC_DEPTH),
        .WIDTH (8)
    ) u_svc_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (clr),
        .i_we    (svc_we),
        .i_waddr (wr_pos[rgtd_pkg::SVC_AW-1:0]),
        .i_wdata (svc_wdata),
        .i_re    (svc_re),
        .i_raddr (i_char_index[rgtd_pkg::SVC_AW-1:0]),
        .o_rdata (svc_rdata)
    );

    rgtd_ram #(
        .DEPTH (rgtd_pkg::TXT_DEPTH),
        .WIDTH (8)
    ) u_txt_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (clr),
        .i_we    (txt_we),
        .i_waddr (txt_waddr),
        .i_wdata (txt_wdata),
        .i_re    (txt_re),
        .i_raddr (i_char_index),
        .o_rdata (txt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_last_ab  <= 1'b0;
            r_new_text <= 1'b0;
            r_type     <= 5'd0;
            r_id       <= 16'd0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mode    <= rgtd_pkg::t_mode'(i_mode);
                        r_k       <= 2'd0;
                        r_cr      <= 1'b0;
                        r_acc     <= 1'b0;
                        r_cplt    <= 1'b0;
                        r_svc_oor <= (i_char_index[5:3] != 3'd0);
                        r_state   <= S_FINISH;
                        unique case (rgtd_pkg::t_mode'(i_mode))
                            rgtd_pkg::MODE_DECODE: begin
                                if (grp_ok) begin
                                    r_acc  <= 1'b1;
                                    r_cplt <= (gtype == rgtd_pkg::GRP_PS)
                                           && (i_block_b[1:0] == 2'd3);
                                    r_type <= i_block_b[9:5];
                                    r_id   <= i_block_a;
                                    if (gtype == rgtd_pkg::GRP_PS) begin
                                        r_to_svc   <= 1'b1;
                                        r_is_2a    <= 1'b0;
                                        r_last     <= 2'd1;
                                        r_base     <= {3'd0, i_block_b[1:0], 1'b0};
                                        r_bytes[0] <= i_block_d[15:8];
                                        r_bytes[1] <= i_block_d[7:0];
                                        r_bytes[2] <= i_block_d[15:8];
                                        r_bytes[3] <= i_block_d[7:0];
                                        r_state    <= S_WRITE;
                                    end else if (gtype == rgtd_pkg::GRP_RT) begin
                                        r_to_svc   <= 1'b0;
                                        r_new_text <= (i_block_b[4] != r_last_ab);
                                        r_last_ab  <= i_block_b[4];
                                        r_state    <= S_WRITE;
                                        if (!i_block_b[11]) begin
                                            r_is_2a    <= 1'b1;
                                            r_last     <= 2'd3;
                                            r_base     <= {i_block_b[3:0], 2'd0};
                                            r_bytes[0] <= i_block_c[15:8];
                                            r_bytes[1] <= i_block_c[7:0];
                                            r_bytes[2] <= i_block_d[15:8];
                                            r_bytes[3] <= i_block_d[7:0];
                                        end else begin
                                            r_is_2a    <= 1'b0;
                                            r_last     <= 2'd1;
                                            r_base     <= {1'b0, i_block_b[3:0], 1'b0};
                                            r_bytes[0] <= i_block_d[15:8];
                                            r_bytes[1] <= i_block_d[7:0];
                                            r_bytes[2] <= i_block_d[15:8];
                                            r_bytes[3] <= i_block_d[7:0];
                                        end
                                    end
                                end
                            end
                            rgtd_pkg::MODE_CLEAR: begin
                                r_type <= 5'd0;
                                r_id   <= 16'd0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_WRITE: begin
                    if (r_is_2a && wr_byte == rgtd_pkg::C_CR) begin
                        r_cr   <= 1'b1;
                        r_fill <= wr_pos;
                    end
                    if (r_k == r_last) begin
                        if (r_cr || (r_is_2a && wr_byte == rgtd_pkg::C_CR)) begin
                            r_state <= S_FILL;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_FILL: begin
                    if (r_fill == rgtd_pkg::TXT_AW'(rgtd_pkg::TXT_DEPTH - 1)) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_fill <= r_fill + rgtd_pkg::TXT_AW'(1);
                    end
                end
                S_FINISH: begin
                    r_valid    <= 1'b1;
                    r_out_acc  <= r_acc;
                    r_out_cplt <= r_cplt;
                    r_out_new  <= r_new_text;
                    r_out_type <= r_type;
                    r_out_id   <= r_id;
                    case (r_mode)
                        rgtd_pkg::MODE_READ_PS: r_out_char <= r_svc_oor ? 8'd0 : svc_rdata;
                        rgtd_pkg::MODE_READ_RT: r_out_char <= txt_rdata;
                        default:                r_out_char <= 8'd0;
                    endcase
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid            = r_valid;
    assign o_accepted         = r_out_acc;
    assign o_service_complete = r_out_cplt;
    assign o_new_text         = r_out_new;
    assign o_program_type     = r_out_type;
    assign o_program_id       = r_out_id;
    assign o_char_value       = r_out_char;

    `RGTD_ASSERT_NXT(a_start_sets_busy, i_clk, i_rst_n, accept, busy, "start beat did not raise busy")
    `RGTD_ASSERT_IMP(a_strobe_after_finish, i_clk, i_rst_n, r_valid, $past(r_state == S_FINISH), "result strobe without finish")
    `RGTD_ASSERT_IMP(a_cplt_needs_acc, i_clk, i_rst_n, o_valid && o_service_complete, o_accepted, "service complete on rejected group")
    `RGTD_ASSERT_IMP(a_one_ram_write, i_clk, i_rst_n, svc_we, !txt_we, "both rams written in one cycle")
    `RGTD_ASSERT_IMP(a_acc_only_decode, i_clk, i_rst_n, r_valid && r_out_acc, r_mode == rgtd_pkg::MODE_DECODE, "accepted outside decode mode")

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// self-checking bench for rds_group_text_decoder: directed table then random group traffic
// depends on rgtd_pkg (mode enum and constants) and the decoder rtl

module tb;

    typedef struct packed {
        rgtd_pkg::t_mode mode;
        logic            read_ok;
        logic [15:0]     status;
        logic [15:0]     errs;
        logic [15:0]     blk_a;
        logic [15:0]     blk_b;
        logic [15:0]     blk_c;
        logic [15:0]     blk_d;
        logic [5:0]      idx;
    } t_grp_cmd;

    typedef struct packed {
        logic        accepted;
        logic        svc_done;
        logic        new_text;
        logic [4:0]  ptype;
        logic [15:0] pid;
        logic [7:0]  chr;
    } t_decode_out;

    typedef struct {
        t_grp_cmd    cmd;
        logic        fixed;
        t_decode_out want;
    } t_dir_row;

    localparam t_decode_out BLANK_OUT = '0;
    localparam int          DIR_N     = 25;
    localparam int          RAND_N    = 525;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    rgtd_pkg::t_mode i_mode = rgtd_pkg::MODE_DECODE;
    logic            i_read_ok = 1'b0;
    logic [15:0]     i_rds_status = '0;
    logic [15:0]     i_error_flags = '0;
    logic [15:0]     i_block_a = '0;
    logic [15:0]     i_block_b = '0;
    logic [15:0]     i_block_c = '0;
    logic [15:0]     i_block_d = '0;
    logic [5:0]      i_char_index = '0;
    logic            busy;
    logic            o_valid;
    logic            o_accepted;
    logic            o_service_complete;
    logic            o_new_text;
    logic [4:0]      o_program_type;
    logic [15:0]     o_program_id;
    logic [7:0]      o_char_value;

    rds_group_text_decoder i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_mode             (i_mode),
        .i_read_ok          (i_read_ok),
        .i_rds_status       (i_rds_status),
        .i_error_flags      (i_error_flags),
        .i_block_a          (i_block_a),
        .i_block_b          (i_block_b),
        .i_block_c          (i_block_c),
        .i_block_d          (i_block_d),
        .i_char_index       (i_char_index),
        .o_valid            (o_valid),
        .o_accepted         (o_accepted),
        .o_service_complete (o_service_complete),
        .o_new_text         (o_new_text),
        .o_program_type     (o_program_type),
        .o_program_id       (o_program_id),
        .o_char_value       (o_char_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // shadow copy of the decoder stores
    logic [7:0]  ps_mem [rgtd_pkg::SVC_DEPTH];
    logic [7:0]  rt_mem [rgtd_pkg::TXT_DEPTH];
    logic        ab_last;
    logic        nt_flag;
    logic [4:0]  pty_q;
    logic [15:0] pi_q;

    t_decode_out outputs_due [$];
    t_decode_out head_want;
    int          fail_count = 0;

    t_dir_row dir_tbl [DIR_N] = '{
        '{'{rgtd_pkg::MODE_READ_PS, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 6'd0}, 1'b1, BLANK_OUT},
        '{'{rgtd_pkg::MODE_READ_RT, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 6'd63}, 1'b1, BLANK_OUT},
        // rejected: read failed, empty block b, no data, block errors
        '{'{rgtd_pkg::MODE_DECODE, 1'b0, 16'h8000, 16'h0000, 16'h1234, 16'h2010, 16'h4142,
            16'h4344, 6'd0}, 1'b1, BLANK_OUT},
        '{'{rgtd_pkg::MODE_DECODE, 1'b1, 16'h8000, 16'h0000, 16'h1234, 16'h0000, 16'h4142,
            16'h4344, 6'd0}, 1'b1, BLANK_OUT},
        '{'{rgtd_pkg::MODE_DECODE, 1'b1, 16'h7FFF, 16'h0000, 16'h1234, 16'h2010, 16'h4142,
            16'h4344, 6'd0}, 1'b1, BLANK_OUT},
        '{'{rgtd_pkg::MODE_DECODE, 1'b1, 16'hFFFF, 16'h0800, 16'h1234, 16'h2010, 16'h4142,
            16'h4344, 6'd0}, 1'b1, BLANK_OUT},
        '{'{rgtd_pkg::MODE_DECODE, 1'b1, 16'hFFFF, 16'h0200, 16'h1234, 16'h2010, 16'h4142,
            16'h4344, 6'd0}, 1'b1, BLANK_OUT},
        // group 0, last segment, max pty and pi
        '{'{rgtd_pkg::MODE_DECODE, 1'b1, 16'h8000, 16'hF5FF, 16'hFFFF, 16'h03E3, 16'h0000,
            16'hFFFF, 6'd0}, 1'b1, '{1'b1, 1'b1, 1'b0, 5'd31, 16'hFFFF, 8'h00}},
        '{'{rgtd_pkg::MODE_READ_PS, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 6'd6}, 1'b0, BLANK_OUT},
        '{'{rgtd_pkg::MODE_DECODE, 1'b1, 16'h8000, 16'h0000, 16'h0001, 16'h0001, 16'h0000,
            16'h4100, 6'd0}, 1'b0, BLANK_OUT},
        '{'{rgtd_pkg::MODE_READ_PS, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 6'd2}, 1'b0, BLANK_OUT},
        '{'{rgtd_pkg::MODE_READ_PS, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 6'd8}, 1'b0, BLANK_OUT},
        // 2a with carriage return, a/b toggles
        '{'{rgtd_pkg::MODE_DECODE, 1'b1, 16'h8000, 16'h0000, 16'hBEEF, 16'h2010, 16'h4845,
            16'h0D58, 6'd0}, 1'b0, BLANK_OUT},
        '{'{rgtd_pkg::MODE_READ_RT, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 6'd1}, 1'b0, BLANK_OUT},
        '{'{rgtd_pkg::MODE_READ_RT, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 6'd2}, 1'b0, BLANK_OUT},
        '{'{rgtd_pkg::MODE_READ_RT, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 6'd63}, 1'b0, BLANK_OUT},
        // 2a last segment: zero, control, delete and tilde bytes
        '{'{rgtd_pkg::MODE_DECODE, 1'b1, 16'h8000, 16'h0000, 16'h00FF, 16'h201F, 16'h0001,
            16'h7F7E, 6'd0}, 1'b0, BLANK_OUT},
        '{'{rgtd_pkg::MODE_READ_RT, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 6'd61}, 1'b0, BLANK_OUT},
        // several carriage returns, the last one sets the fill start
        '{'{rgtd_pkg::MODE_DECODE, 1'b1, 16'h8000, 16'h0000, 16'h5555, 16'h2005, 16'h0D0D,
            16'h410D, 6'd0}, 1'b0, BLANK_OUT},
        '{'{rgtd_pkg::MODE_DECODE, 1'b1, 16'h8000, 16'h0000, 16'hAAAA, 16'h281F, 16'h0000,
            16'h0042, 6'd0}, 1'b0, BLANK_OUT},
        // other group type only updates pty and pi
        '{'{rgtd_pkg::MODE_DECODE, 1'b1, 16'hFFFF, 16'hF5FF, 16'h0000, 16'hFFFF, 16'hFFFF,
            16'hFFFF, 6'd63}, 1'b0, BLANK_OUT},
        '{'{rgtd_pkg::MODE_READ_RT, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 6'd31}, 1'b0, BLANK_OUT},
        '{'{rgtd_pkg::MODE_CLEAR, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
            16'hFFFF, 6'd63}, 1'b0, BLANK_OUT},
        '{'{rgtd_pkg::MODE_READ_PS, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 6'd7}, 1'b0, BLANK_OUT},
        '{'{rgtd_pkg::MODE_READ_RT, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 6'd0}, 1'b0, BLANK_OUT}
    };

    function automatic logic [7:0] scrub(logic [7:0] c);
        if ((c != 8'd0 && c < rgtd_pkg::C_SPACE) || c > rgtd_pkg::C_CHAR_MAX) begin
            return rgtd_pkg::C_SPACE;
        end
        return c;
    endfunction

    // updates the shadow stores and returns what the beat should report
    function automatic t_decode_out decode_predict(t_grp_cmd c);
        t_decode_out r;
        logic [31:0] cd;
        logic [7:0]  chr;
        logic [5:0]  pos;
        logic [3:0]  seg;
        int          fill;
        r = '0;
        case (c.mode)
            rgtd_pkg::MODE_DECODE: begin
                if (c.read_ok && c.blk_b != '0 && (c.status & rgtd_pkg::C_STATUS_AVAIL) != '0
                        && (c.errs & rgtd_pkg::C_ERR_MASK) == '0) begin
                    r.accepted = 1'b1;
                    pty_q = c.blk_b[9:5];
                    pi_q = c.blk_a;
                    seg = c.blk_b[3:0];
                    if (c.blk_b[15:12] == rgtd_pkg::GRP_PS) begin
                        if (c.blk_d[15:8] != 8'd0)
                            ps_mem[{seg[1:0], 1'b0}] = scrub(c.blk_d[15:8]);
                        if (c.blk_d[7:0] != 8'd0)
                            ps_mem[{seg[1:0], 1'b1}] = scrub(c.blk_d[7:0]);
                        r.svc_done = (seg[1:0] == 2'd3);
                    end else if (c.blk_b[15:12] == rgtd_pkg::GRP_RT) begin
                        fill = rgtd_pkg::TXT_DEPTH;
                        if (!c.blk_b[11]) begin
                            cd = {c.blk_c, c.blk_d};
                            for (int k = 0; k < 4; k++) begin
                                chr = cd[31 - 8 * k -: 8];
                                pos = {seg, 2'(k)};
                                if (chr != rgtd_pkg::C_CR) begin
                                    rt_mem[pos] = scrub(chr);
                                end else begin
                                    fill = pos;
                                end
                            end
                        end else begin
                            if (c.blk_d[15:8] != 8'd0)
                                rt_mem[{1'b0, seg, 1'b0}] = scrub(c.blk_d[15:8]);
                            if (c.blk_d[7:0] != 8'd0)
                                rt_mem[{1'b0, seg, 1'b1}] = scrub(c.blk_d[7:0]);
                        end
                        for (int k = fill; k < rgtd_pkg::TXT_DEPTH; k++)
                            rt_mem[k] = rgtd_pkg::C_SPACE;
                        nt_flag = (c.blk_b[4] != ab_last);
                        ab_last = c.blk_b[4];
                    end
                end
            end
            rgtd_pkg::MODE_READ_PS:
                r.chr = (c.idx < rgtd_pkg::SVC_DEPTH) ? ps_mem[c.idx[2:0]] : 8'd0;
            rgtd_pkg::MODE_READ_RT: r.chr = rt_mem[c.idx];
            default: begin
                foreach (ps_mem[i]) ps_mem[i] = 8'd0;
                foreach (rt_mem[i]) rt_mem[i] = 8'd0;
                pty_q = '0;
                pi_q = '0;
            end
        endcase
        r.new_text = nt_flag;
        r.ptype = pty_q;
        r.pid = pi_q;
        return r;
    endfunction

    // text bytes weighted toward the interesting classes
    function automatic logic [7:0] pick_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return 8'($urandom_range(32, 126));
        if (sel < 62) return rgtd_pkg::C_CR;
        if (sel < 72) return 8'd0;
        if (sel < 82) return 8'($urandom_range(1, 31));
        return 8'($urandom_range(127, 255));
    endfunction

    function automatic t_grp_cmd make_random_cmd();
        t_grp_cmd c;
        int       sel;
        int       gsel;
        sel = $urandom_range(0, 99);
        c.mode = rgtd_pkg::MODE_DECODE;
        c.read_ok = 1'b1;
        c.status = 16'($urandom) | rgtd_pkg::C_STATUS_AVAIL;
        c.errs = 16'($urandom) & ~rgtd_pkg::C_ERR_MASK;
        c.blk_a = 16'($urandom);
        c.blk_b = 16'($urandom);
        c.blk_c = {pick_char(), pick_char()};
        c.blk_d = {pick_char(), pick_char()};
        c.idx = 6'($urandom_range(0, 63));
        if (sel < 55) begin
            gsel = $urandom_range(0, 9);
            if (gsel < 3) begin
                c.blk_b[15:12] = rgtd_pkg::GRP_PS;
            end else if (gsel < 8) begin
                c.blk_b[15:12] = rgtd_pkg::GRP_RT;
                c.blk_b[11] = (gsel >= 6);
            end
            if (c.blk_b == '0) c.blk_b[4] = 1'b1;
        end else if (sel < 63) begin
            case ($urandom_range(0, 3))
                0: c.read_ok = 1'b0;
                1: c.blk_b = '0;
                2: c.status = c.status & ~rgtd_pkg::C_STATUS_AVAIL;
                default: begin
                    c.errs = 16'($urandom);
                    if ((c.errs & rgtd_pkg::C_ERR_MASK) == '0)
                        c.errs = c.errs | rgtd_pkg::C_ERR_MASK;
                end
            endcase
        end else if (sel < 80) begin
            c.mode = rgtd_pkg::MODE_READ_PS;
            if ($urandom_range(0, 1) == 0) c.idx = 6'($urandom_range(0, 9));
        end else if (sel < 97) begin
            c.mode = rgtd_pkg::MODE_READ_RT;
        end else begin
            c.mode = rgtd_pkg::MODE_CLEAR;
        end
        return c;
    endfunction

    task automatic send_cmd(t_grp_cmd c, logic fixed, t_decode_out typed);
        t_decode_out guess;
        start <= 1'b1;
        i_mode <= c.mode;
        i_read_ok <= c.read_ok;
        i_rds_status <= c.status;
        i_error_flags <= c.errs;
        i_block_a <= c.blk_a;
        i_block_b <= c.blk_b;
        i_block_c <= c.blk_c;
        i_block_d <= c.blk_d;
        i_char_index <= c.idx;
        do @(posedge i_clk); while (busy);
        guess = decode_predict(c);
        outputs_due.push_back(fixed ? typed : guess);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (outputs_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic maybe_idle(logic calm);
        if (!calm && $urandom_range(0, 99) < 27) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (outputs_due.size() == 0) begin
                $error("result beat with nothing outstanding");
                fail_count++;
            end else begin
                head_want = outputs_due.pop_front();
                check_field("accepted", head_want.accepted, o_accepted);
                check_field("service_complete", head_want.svc_done, o_service_complete);
                check_field("new_text", head_want.new_text, o_new_text);
                check_field("program_type", head_want.ptype, o_program_type);
                check_field("program_id", head_want.pid, o_program_id);
                check_field("char_value", head_want.chr, o_char_value);
            end
        end
    end

    initial begin
        int calm_from;
        foreach (ps_mem[i]) ps_mem[i] = 8'd0;
        foreach (rt_mem[i]) rt_mem[i] = 8'd0;
        ab_last = 1'b0;
        nt_flag = 1'b0;
        pty_q = '0;
        pi_q = '0;
        calm_from = $urandom_range(100, 350);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_tbl[i]) begin
            send_cmd(dir_tbl[i].cmd, dir_tbl[i].fixed, dir_tbl[i].want);
            maybe_idle(1'b0);
        end
        drain_results();
        for (int n = 0; n < RAND_N; n++) begin
            send_cmd(make_random_cmd(), 1'b0, BLANK_OUT);
            if (n == RAND_N / 2) begin
                drain_results();
            end else begin
                maybe_idle(n >= calm_from && n < calm_from + 120);
            end
        end
        drain_results();
        repeat (80) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
